### hw/rtl/vnorm_pkg.sv
// Shared types and constants of the vertex normal unit.
// No dependencies; the interfaces, the square root, the divider and the top level import it.
`default_nettype none
package vnorm_pkg;
	localparam int COORD_W = 24;
	localparam int IDX_W   = 12;
	localparam int CMD_W   = 2;
	localparam int OUT_W   = 16;
	localparam int NSUM_W  = 64;
	localparam int CROSS_W = 52;
	localparam int MUL_W   = 31;
	localparam int PROD_W  = 62;
	localparam int ROOT_W  = 32;
	localparam int NUM_W   = 46;
	localparam int QUO_W   = 17;

	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TRI   = 2'd2;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [NSUM_W-1:0] nsum_t;
	typedef logic signed [OUT_W-1:0] q15_t;
	typedef logic [2:0][COORD_W-1:0] pos_t;
	typedef logic [2:0][NSUM_W-1:0] nrm_t;

	// handshake-free start/done pair of the iterative units
	typedef struct packed {
		logic start;
		logic done;
	} unit_ctl_t;
endpackage
`default_nettype wire

### hw/rtl/vnorm_cmd_if.sv
// Command channel of the vertex normal unit: valid/ready plus the command fields.
// Depends on vnorm_pkg.
`default_nettype none
interface vnorm_cmd_if import vnorm_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   cmd;
	logic [IDX_W-1:0]   first_index;
	logic [IDX_W-1:0]   second_index;
	logic [IDX_W-1:0]   third_index;
	coord_t             in_x;
	coord_t             in_y;
	coord_t             in_z;

	modport source (output valid, cmd, first_index, second_index, third_index,
		in_x, in_y, in_z, input ready);
	modport sink (input valid, cmd, first_index, second_index, third_index,
		in_x, in_y, in_z, output ready);
endinterface
`default_nettype wire

### hw/rtl/vnorm_res_if.sv
// Result channel of the vertex normal unit: valid/ready plus the result fields.
// Depends on vnorm_pkg.
`default_nettype none
interface vnorm_res_if import vnorm_pkg::*; ();
	logic valid;
	logic ready;
	q15_t unit_nx;
	q15_t unit_ny;
	q15_t unit_nz;
	q15_t out_x;
	q15_t out_y;
	q15_t out_z;
	logic zero_normal;
	logic zero_extent;
	logic status;

	modport source (output valid, unit_nx, unit_ny, unit_nz, out_x, out_y, out_z,
		zero_normal, zero_extent, status, input ready);
	modport sink (input valid, unit_nx, unit_ny, unit_nz, out_x, out_y, out_z,
		zero_normal, zero_extent, status, output ready);
endinterface
`default_nettype wire

### hw/rtl/vnorm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module vnorm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### hw/rtl/vnorm_isqrt.sv
// Bit-pair iterative integer square root, one result bit per cycle.
// Depends on vnorm_pkg.
`default_nettype none
module vnorm_isqrt import vnorm_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [63:0]       value,
	output logic                   done,
	output logic [ROOT_W-1:0]      root
);
	logic        busy_q;
	logic        done_q;
	logic [63:0] v_q;
	logic [63:0] r_q;
	logic [63:0] bit_q;
	logic [63:0] trial;

	assign trial = r_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && bit_q[0];
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= value;
			r_q   <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
		end else if (busy_q) begin
			if (v_q >= trial) begin
				v_q <= v_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = r_q[ROOT_W-1:0];
endmodule
`default_nettype wire

### hw/rtl/vnorm_div.sv
// Restoring divider, one quotient bit per cycle, with a quotient overflow flag.
// Depends on vnorm_pkg.
`default_nettype none
module vnorm_div import vnorm_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [NUM_W-1:0]  num,
	input  wire logic [ROOT_W-1:0] den,
	output logic                   done,
	output logic                   ovf,
	output logic [QUO_W-1:0]       quo
);
	localparam int CNT_W = $clog2(QUO_W + 1);

	logic              prep_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [NUM_W-1:0]  num_q;
	logic [ROOT_W-1:0] den_q;
	logic [ROOT_W:0]   rem_q;
	logic [QUO_W-1:0]  low_q;
	logic [QUO_W-1:0]  quo_q;
	logic              ovf_q;
	logic [ROOT_W:0]   trial;
	logic              ge;

	assign trial = {rem_q[ROOT_W-1:0], low_q[QUO_W-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prep_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			prep_q <= start;
			done_q <= (cnt_q == CNT_W'(1));
			if (prep_q) begin
				cnt_q <= CNT_W'(QUO_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
		end else if (prep_q) begin
			ovf_q <= (num_q >> QUO_W) >= NUM_W'(den_q);
			rem_q <= (ROOT_W + 1)'(num_q >> QUO_W);
			low_q <= num_q[QUO_W-1:0];
		end else if (cnt_q != '0) begin
			rem_q <= ge ? (trial - {1'b0, den_q}) : trial;
			quo_q <= {quo_q[QUO_W-2:0], ge};
			low_q <= low_q << 1;
		end
	end

	assign done = done_q;
	assign ovf  = ovf_q;
	assign quo  = quo_q;
endmodule
`default_nettype wire

### hw/rtl/mesh_vertex_normals_and_unit_scale_unit.sv
// Vertex store with area-weighted smooth normals and unit-scale read-back.
// A clear command zeroes one normal entry per cycle; the same pass runs after
// reset, during which no command is taken. A triangle add does three position
// reads, six products on one multiplier and three read-modify-writes of the
// normal memory. A read runs a shift loop, then a square root and three
// divisions per normalized vector. A finished result waits in the output
// register while the next command is accepted.
// Depends on vnorm_pkg, vnorm_cmd_if, vnorm_res_if, vnorm_ram, vnorm_isqrt, vnorm_div.
`default_nettype none
module mesh_vertex_normals_and_unit_scale_unit import vnorm_pkg::*; #(
	parameter int VERTEX_DEPTH = 4096
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    cfg_wr_en,
	input  wire logic    cfg_wr_data,
	vnorm_cmd_if.sink    cmd_ch,
	vnorm_res_if.source  res_ch
);
	localparam int AW = $clog2(VERTEX_DEPTH);

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_CLR      = 4'd1;
	localparam logic [3:0] ST_TRI_RD   = 4'd2;
	localparam logic [3:0] ST_TRI_EDGE = 4'd3;
	localparam logic [3:0] ST_TRI_MUL  = 4'd4;
	localparam logic [3:0] ST_TRI_NRD  = 4'd5;
	localparam logic [3:0] ST_TRI_NWR  = 4'd6;
	localparam logic [3:0] ST_RD_RAM   = 4'd7;
	localparam logic [3:0] ST_RD_LATCH = 4'd8;
	localparam logic [3:0] ST_SHIFT    = 4'd9;
	localparam logic [3:0] ST_SQ       = 4'd10;
	localparam logic [3:0] ST_SQRT     = 4'd11;
	localparam logic [3:0] ST_DIV      = 4'd12;
	localparam logic [3:0] ST_STD      = 4'd13;
	localparam logic [3:0] ST_FIN      = 4'd14;

	function automatic logic in_rng(logic [IDX_W-1:0] i);
		return 32'(i) < 32'(VERTEX_DEPTH);
	endfunction

	function automatic logic [AW-1:0] to_addr(logic [IDX_W-1:0] i);
		logic [31:0] w;
		w = 32'(i);
		return w[AW-1:0];
	endfunction

	function automatic logic [NSUM_W-1:0] mag64(nsum_t v);
		return v[NSUM_W-1] ? NSUM_W'(-v) : NSUM_W'(v);
	endfunction

	function automatic q15_t sat_q15(logic neg, logic ovf, logic [QUO_W-1:0] q);
		if (neg) begin
			return (ovf || q > QUO_W'(32768)) ? q15_t'(-32768) : q15_t'(-$signed({1'b0, q}));
		end
		return (ovf || q > QUO_W'(32767)) ? q15_t'(32767) : q15_t'(q);
	endfunction

	// control
	logic [3:0]    state_q;
	logic [2:0]    step_q;
	logic [1:0]    k_q;
	logic [AW-1:0] clr_q;
	logic          clr_rsp_q;
	logic          wait_q;
	logic          phase_q;
	logic          res_valid_q;
	logic          std_en_q;
	logic          sat_q;
	coord_t        bmin_q [3];
	coord_t        bmax_q [3];

	// datapath
	logic [CMD_W-1:0]      cmd_q;
	logic [AW-1:0]         addr_q [3];
	pos_t                  tp_q [3];
	pos_t                  p_q;
	logic signed [24:0]    e1_q [3];
	logic signed [24:0]    e2_q [3];
	logic signed [PROD_W-1:0] prod_q;
	logic signed [CROSS_W-1:0] cross_q [3];
	logic [NSUM_W-1:0]     m_q [3];
	logic                  nneg_q [3];
	logic [23:0]           ext_q [3];
	logic [63:0]           ssq_q;
	logic [ROOT_W-1:0]     len_q;
	q15_t                  r_n_q [3];
	q15_t                  r_p_q [3];
	logic                  r_zn_q;
	logic                  r_ze_q;
	q15_t                  o_n_q [3];
	q15_t                  o_p_q [3];
	logic                  o_zn_q;
	logic                  o_ze_q;
	logic                  o_st_q;

	logic accept;
	logic load_out;
	logic tri_ok;
	logic empty_box;
	logic any_big;
	logic all_zero;

	assign accept   = cmd_ch.valid && cmd_ch.ready;
	assign load_out = (state_q == ST_FIN) && (!res_valid_q || res_ch.ready);
	assign tri_ok   = in_rng(cmd_ch.first_index) && in_rng(cmd_ch.second_index)
		&& in_rng(cmd_ch.third_index);

	// memories
	logic                      pos_we;
	logic [AW-1:0]             pos_raddr;
	logic [3*COORD_W-1:0]      pos_rdata;
	logic                      nrm_we;
	logic [AW-1:0]             nrm_waddr;
	logic [3*NSUM_W-1:0]       nrm_wdata;
	logic [AW-1:0]             nrm_raddr;
	logic [3*NSUM_W-1:0]       nrm_rdata;
	pos_t                      pos_rd;
	nrm_t                      nrm_rd;
	nrm_t                      nrm_new;
	logic [2:0]                add_ovf;

	assign pos_we    = accept && cmd_ch.cmd == CMD_WRITE && in_rng(cmd_ch.first_index);
	assign pos_raddr = (state_q == ST_TRI_RD && step_q < 3'd3) ? addr_q[step_q[1:0]] : addr_q[0];
	assign pos_rd    = pos_rdata;
	assign nrm_rd    = nrm_rdata;

	assign nrm_we    = (state_q == ST_CLR) || (state_q == ST_TRI_NWR);
	assign nrm_waddr = (state_q == ST_CLR) ? clr_q : addr_q[k_q];
	assign nrm_wdata = (state_q == ST_CLR) ? '0 : nrm_new;
	assign nrm_raddr = (state_q == ST_TRI_NRD) ? addr_q[k_q] : addr_q[0];

	vnorm_ram #(.WIDTH(3 * COORD_W), .DEPTH(VERTEX_DEPTH)) u_pos_ram (
		.clk   (clk),
		.we    (pos_we),
		.waddr (to_addr(cmd_ch.first_index)),
		.wdata ({cmd_ch.in_z, cmd_ch.in_y, cmd_ch.in_x}),
		.raddr (pos_raddr),
		.rdata (pos_rdata)
	);

	vnorm_ram #(.WIDTH(3 * NSUM_W), .DEPTH(VERTEX_DEPTH)) u_nrm_ram (
		.clk   (clk),
		.we    (nrm_we),
		.waddr (nrm_waddr),
		.wdata (nrm_wdata),
		.raddr (nrm_raddr),
		.rdata (nrm_rdata)
	);

	// saturating accumulate of the cross product into one corner
	always_comb begin
		logic signed [NSUM_W:0] s;
		for (int j = 0; j < 3; j++) begin
			s = {nrm_rd[j][NSUM_W-1], nrm_rd[j]}
				+ (NSUM_W + 1)'(cross_q[j]);
			add_ovf[j] = s[NSUM_W] != s[NSUM_W-1];
			if (add_ovf[j]) begin
				nrm_new[j] = s[NSUM_W] ? {1'b1, {(NSUM_W-1){1'b0}}}
					: {1'b0, {(NSUM_W-1){1'b1}}};
			end else begin
				nrm_new[j] = s[NSUM_W-1:0];
			end
		end
	end

	always_comb begin
		empty_box = 1'b0;
		any_big   = 1'b0;
		all_zero  = 1'b1;
		for (int j = 0; j < 3; j++) begin
			empty_box = empty_box || (bmin_q[j] > bmax_q[j]);
			any_big   = any_big || (m_q[j][NSUM_W-1:30] != '0);
			all_zero  = all_zero && (nrm_rd[j] == '0);
		end
	end

	// shared multiplier operands
	logic signed [MUL_W-1:0] mul_a;
	logic signed [MUL_W-1:0] mul_b;
	logic [MUL_W-1:0]        sq_op;

	always_comb begin
		sq_op = phase_q ? MUL_W'(ext_q[step_q[1:0] == 2'd3 ? 2'd2 : step_q[1:0]])
			: MUL_W'(m_q[step_q[1:0] == 2'd3 ? 2'd2 : step_q[1:0]][29:0]);
		mul_a = '0;
		mul_b = '0;
		if (state_q == ST_TRI_MUL) begin
			unique case (step_q)
				3'd0: begin mul_a = MUL_W'(e1_q[1]); mul_b = MUL_W'(e2_q[2]); end
				3'd1: begin mul_a = MUL_W'(e1_q[2]); mul_b = MUL_W'(e2_q[1]); end
				3'd2: begin mul_a = MUL_W'(e1_q[2]); mul_b = MUL_W'(e2_q[0]); end
				3'd3: begin mul_a = MUL_W'(e1_q[0]); mul_b = MUL_W'(e2_q[2]); end
				3'd4: begin mul_a = MUL_W'(e1_q[0]); mul_b = MUL_W'(e2_q[1]); end
				3'd5: begin mul_a = MUL_W'(e1_q[1]); mul_b = MUL_W'(e2_q[0]); end
				default: begin mul_a = '0; mul_b = '0; end
			endcase
		end else if (state_q == ST_SQ) begin
			mul_a = $signed(sq_op);
			mul_b = $signed(sq_op);
		end
	end

	// iterative units
	unit_ctl_t         sq_ctl;
	unit_ctl_t         dv_ctl;
	logic [63:0]       sq_value;
	logic [ROOT_W-1:0] sq_root;
	logic [NUM_W-1:0]  dv_num;
	logic              dv_neg;
	logic              dv_ovf;
	logic [QUO_W-1:0]  dv_quo;
	logic signed [25:0] dval;
	logic [25:0]       dmag;

	assign sq_ctl.start = (state_q == ST_SQRT) && !wait_q && !(phase_q && ssq_q == '0);
	assign dv_ctl.start = (state_q == ST_DIV) && !wait_q;
	assign sq_value     = phase_q ? (ssq_q << 8) : ssq_q;

	always_comb begin
		dval = (26'($signed(p_q[k_q])) <<< 1)
			- (26'(bmin_q[k_q]) + 26'(bmax_q[k_q]));
		dmag = dval[25] ? 26'(-dval) : 26'(dval);
		if (phase_q) begin
			dv_num = NUM_W'({dmag, 19'b0}) + NUM_W'(len_q >> 1);
			dv_neg = dval[25];
		end else begin
			dv_num = NUM_W'({m_q[k_q][29:0], 15'b0}) + NUM_W'(len_q >> 1);
			dv_neg = nneg_q[k_q];
		end
	end

	vnorm_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_ctl.start),
		.value  (sq_value),
		.done   (sq_ctl.done),
		.root   (sq_root)
	);

	vnorm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dv_ctl.start),
		.num    (dv_num),
		.den    (len_q),
		.done   (dv_ctl.done),
		.ovf    (dv_ovf),
		.quo    (dv_quo)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			step_q      <= '0;
			k_q         <= '0;
			clr_q       <= '0;
			clr_rsp_q   <= 1'b0;
			wait_q      <= 1'b0;
			phase_q     <= 1'b0;
			res_valid_q <= 1'b0;
			std_en_q    <= 1'b0;
			sat_q       <= 1'b0;
			for (int j = 0; j < 3; j++) begin
				bmin_q[j] <= {1'b0, {(COORD_W-1){1'b1}}};
				bmax_q[j] <= {1'b1, {(COORD_W-1){1'b0}}};
			end
		end else begin
			if (cfg_wr_en) begin
				std_en_q <= cfg_wr_data;
			end
			if (load_out) begin
				res_valid_q <= 1'b1;
			end else if (res_ch.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						step_q <= '0;
						k_q    <= '0;
						unique case (cmd_ch.cmd)
							CMD_CLEAR: begin
								sat_q     <= 1'b0;
								clr_q     <= '0;
								clr_rsp_q <= 1'b1;
								for (int j = 0; j < 3; j++) begin
									bmin_q[j] <= {1'b0, {(COORD_W-1){1'b1}}};
									bmax_q[j] <= {1'b1, {(COORD_W-1){1'b0}}};
								end
								state_q <= ST_CLR;
							end
							CMD_WRITE: begin
								if (pos_we) begin
									if (cmd_ch.in_x < bmin_q[0]) bmin_q[0] <= cmd_ch.in_x;
									if (cmd_ch.in_x > bmax_q[0]) bmax_q[0] <= cmd_ch.in_x;
									if (cmd_ch.in_y < bmin_q[1]) bmin_q[1] <= cmd_ch.in_y;
									if (cmd_ch.in_y > bmax_q[1]) bmax_q[1] <= cmd_ch.in_y;
									if (cmd_ch.in_z < bmin_q[2]) bmin_q[2] <= cmd_ch.in_z;
									if (cmd_ch.in_z > bmax_q[2]) bmax_q[2] <= cmd_ch.in_z;
								end
								state_q <= ST_FIN;
							end
							CMD_TRI: begin
								state_q <= tri_ok ? ST_TRI_RD : ST_FIN;
							end
							CMD_READ: begin
								state_q <= in_rng(cmd_ch.first_index) ? ST_RD_RAM : ST_FIN;
							end
							default: state_q <= ST_FIN;
						endcase
					end
				end
				ST_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(VERTEX_DEPTH - 1)) begin
						state_q <= clr_rsp_q ? ST_FIN : ST_IDLE;
					end
				end
				ST_TRI_RD: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd3) state_q <= ST_TRI_EDGE;
				end
				ST_TRI_EDGE: begin
					step_q  <= '0;
					state_q <= ST_TRI_MUL;
				end
				ST_TRI_MUL: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd6) begin
						k_q     <= '0;
						state_q <= ST_TRI_NRD;
					end
				end
				ST_TRI_NRD: state_q <= ST_TRI_NWR;
				ST_TRI_NWR: begin
					sat_q <= sat_q | (|add_ovf);
					k_q   <= k_q + 2'd1;
					state_q <= (k_q == 2'd2) ? ST_FIN : ST_TRI_NRD;
				end
				ST_RD_RAM: state_q <= ST_RD_LATCH;
				ST_RD_LATCH: begin
					phase_q <= 1'b0;
					step_q  <= '0;
					state_q <= all_zero ? ST_STD : ST_SHIFT;
				end
				ST_SHIFT: begin
					if (!any_big) state_q <= ST_SQ;
				end
				ST_SQ: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd3) begin
						wait_q  <= 1'b0;
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (!wait_q) begin
						if (phase_q && ssq_q == '0) begin
							state_q <= ST_FIN;
						end else begin
							wait_q <= 1'b1;
						end
					end else if (sq_ctl.done) begin
						wait_q  <= 1'b0;
						k_q     <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (!wait_q) begin
						wait_q <= 1'b1;
					end else if (dv_ctl.done) begin
						wait_q <= 1'b0;
						k_q    <= k_q + 2'd1;
						if (k_q == 2'd2) state_q <= phase_q ? ST_FIN : ST_STD;
					end
				end
				ST_STD: begin
					step_q  <= '0;
					phase_q <= 1'b1;
					state_q <= (!std_en_q || empty_box) ? ST_FIN : ST_SQ;
				end
				ST_FIN: begin
					if (load_out) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd_q     <= cmd_ch.cmd;
					addr_q[0] <= to_addr(cmd_ch.first_index);
					addr_q[1] <= to_addr(cmd_ch.second_index);
					addr_q[2] <= to_addr(cmd_ch.third_index);
					r_zn_q    <= 1'b0;
					r_ze_q    <= 1'b0;
					for (int j = 0; j < 3; j++) begin
						r_n_q[j] <= '0;
						r_p_q[j] <= '0;
					end
				end
			end
			ST_TRI_RD: begin
				if (step_q != 3'd0) tp_q[step_q[1:0] - 2'd1] <= pos_rd;
			end
			ST_TRI_EDGE: begin
				for (int j = 0; j < 3; j++) begin
					e1_q[j] <= 25'($signed(tp_q[1][j])) - 25'($signed(tp_q[0][j]));
					e2_q[j] <= 25'($signed(tp_q[2][j])) - 25'($signed(tp_q[1][j]));
				end
			end
			ST_TRI_MUL: begin
				// even products open a component, odd ones are subtracted
				if (step_q != 3'd0) begin
					if (step_q[0]) begin
						cross_q[step_q[2:1]] <= CROSS_W'(prod_q);
					end else begin
						cross_q[step_q[2:1] - 2'd1] <= cross_q[step_q[2:1] - 2'd1]
							- CROSS_W'(prod_q);
					end
				end
			end
			ST_RD_LATCH: begin
				p_q    <= pos_rd;
				r_zn_q <= all_zero;
				for (int j = 0; j < 3; j++) begin
					m_q[j]    <= mag64(nrm_rd[j]);
					nneg_q[j] <= nrm_rd[j][NSUM_W-1];
				end
			end
			ST_SHIFT: begin
				if (any_big) begin
					for (int j = 0; j < 3; j++) m_q[j] <= m_q[j] >> 1;
				end
			end
			ST_SQ: begin
				if (step_q == 3'd1) begin
					ssq_q <= 64'($unsigned(prod_q));
				end else if (step_q != 3'd0) begin
					ssq_q <= ssq_q + 64'($unsigned(prod_q));
				end
			end
			ST_SQRT: begin
				if (!wait_q && phase_q && ssq_q == '0) r_ze_q <= 1'b1;
				if (wait_q && sq_ctl.done) len_q <= sq_root;
			end
			ST_DIV: begin
				if (wait_q && dv_ctl.done) begin
					if (phase_q) r_p_q[k_q] <= sat_q15(dv_neg, dv_ovf, dv_quo);
					else r_n_q[k_q] <= sat_q15(dv_neg, dv_ovf, dv_quo);
				end
			end
			ST_STD: begin
				if (!std_en_q) begin
					for (int j = 0; j < 3; j++) r_p_q[j] <= q15_t'(p_q[j][COORD_W-1 -: OUT_W]);
				end else if (empty_box) begin
					r_ze_q <= 1'b1;
				end else begin
					for (int j = 0; j < 3; j++) ext_q[j] <= 24'(bmax_q[j] - bmin_q[j]);
				end
			end
			ST_FIN: begin
				if (load_out) begin
					o_n_q  <= r_n_q;
					o_p_q  <= r_p_q;
					o_zn_q <= r_zn_q;
					o_ze_q <= r_ze_q;
					o_st_q <= sat_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign cmd_ch.ready       = (state_q == ST_IDLE);
	assign res_ch.valid       = res_valid_q;
	assign res_ch.unit_nx     = o_n_q[0];
	assign res_ch.unit_ny     = o_n_q[1];
	assign res_ch.unit_nz     = o_n_q[2];
	assign res_ch.out_x       = o_p_q[0];
	assign res_ch.out_y       = o_p_q[1];
	assign res_ch.out_z       = o_p_q[2];
	assign res_ch.zero_normal = o_zn_q;
	assign res_ch.zero_extent = o_ze_q;
	assign res_ch.status      = o_st_q;

	// a finished command cannot skip the result stage
	a_res_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q) == ST_FIN)
		else $error("result raised outside the finish stage");

	a_zn_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_ch.valid && res_ch.zero_normal |->
			res_ch.unit_nx == '0 && res_ch.unit_ny == '0 && res_ch.unit_nz == '0)
		else $error("zero normal flag with a nonzero normal");

	a_ze_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_ch.valid && res_ch.zero_extent |->
			res_ch.out_x == '0 && res_ch.out_y == '0 && res_ch.out_z == '0)
		else $error("zero extent flag with a nonzero position");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !cmd_ch.ready)
		else $error("second transfer taken before the first finished");

	a_nrm_write_owner: assert property (@(posedge clk) disable iff (!arst_n)
		dv_ctl.start |-> !sq_ctl.start && cmd_q == CMD_READ)
		else $error("divider started outside a read");
endmodule
`default_nettype wire
